// File: design/fbp_pkg.sv
`timescale 1ns / 1ps
package fbp_pkg;

  localparam int DATA_W        = 8;
  localparam int IDX_W         = 16;
  localparam int SIZE_W        = 31;
  localparam int PSIZE_W       = 14;
  localparam int IN_TDATA_W    = 56;
  localparam int OUT_TUSER_W   = 3;

  localparam logic [PSIZE_W-1:0] PAYLOAD_RESET = 14'd1392;
  localparam logic [PSIZE_W-1:0] PAYLOAD_MAX   = 14'd9000;

  localparam int HDR_BYTES = 8;
  localparam int STEP_W    = $clog2(HDR_BYTES + 1);
  localparam int HSEL_W    = $clog2(HDR_BYTES);

  localparam int FIFO_DEPTH_DEF = 4;

  // One classified item on its way from the front to the back
  typedef struct packed {
    logic [DATA_W-1:0] data_byte;
    logic              need_hdr;
    logic [IDX_W-1:0]  frame_index;
    logic [IDX_W-1:0]  packet_number;
    logic [SIZE_W-1:0] frame_size;
    logic              packet_end;
    logic              frame_end;
  } fbp_entry_t;

  // Big-endian header: frame index, packet number, 32-bit frame size
  function automatic logic [DATA_W-1:0] fbp_hdr_byte(fbp_entry_t e,
                                                     logic [HSEL_W-1:0] sel);
    logic [DATA_W-1:0] b;
    case (sel)
      3'd0:    b = e.frame_index[15:8];
      3'd1:    b = e.frame_index[7:0];
      3'd2:    b = e.packet_number[15:8];
      3'd3:    b = e.packet_number[7:0];
      3'd4:    b = {1'b0, e.frame_size[30:24]};
      3'd5:    b = e.frame_size[23:16];
      3'd6:    b = e.frame_size[15:8];
      3'd7:    b = e.frame_size[7:0];
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// File: design/frame_byte_packetizer_top.sv
`timescale 1ns / 1ps
// A payload byte passes through the queue and the output register; a byte that
// opens a packet first brings its 8 header bytes, one per cycle unless stalled.
// Throughput: one item per cycle in while the queue has room, one output byte
// per cycle out unless stalled; queue and output backpressure absorb the 8
// header bytes of each packet. Reset: clears all frame and packet counters,
// empties the queue and sets payload_size to 1392; no clearing pass is needed.
module frame_byte_packetizer_top #(
  parameter int FIFO_DEPTH = fbp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream, tdata: data_byte [7:0], frame_index [23:8], frame_size [54:24]
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [fbp_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // Output stream, tdata: out_byte [7:0]
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [fbp_pkg::DATA_W-1:0]          m_axis_tdata,
  // tuser: is_header [0], packet_end [1], frame_end [2]; tlast: last_of_run
  output logic [fbp_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  output logic                                m_axis_tlast,
  // Configuration write: payload_size
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [fbp_pkg::PSIZE_W-1:0]         cfg_data_i
);
  import fbp_pkg::*;

  logic [PSIZE_W-1:0] psize_q, psize_d;
  logic               push, full, pop, q_valid;
  fbp_entry_t         entry, head;

  // Take configuration at any time; the user must only write it while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;

  always_comb begin
    psize_d = psize_q;
    if (cfg_valid_i) begin
      psize_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psize_q <= PAYLOAD_RESET;
    end else begin
      psize_q <= psize_d;
    end
  end

  // Front: sample frame fields, track offsets, classify each item
  fbp_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .data_byte_i    (s_axis_tdata[7:0]),
    .frame_index_i  (s_axis_tdata[23:8]),
    .frame_size_i   (s_axis_tdata[54:24]),
    .payload_size_i (psize_q),
    .full_i         (full),
    .push_o         (push),
    .entry_o        (entry)
  );

  // Queue: decouple the front from the header expansion
  fbp_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .head_o  (head)
  );

  // Back: expand into header and payload bytes through the output register
  fbp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: design/fbp_front.sv
`timescale 1ns / 1ps
module fbp_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fbp_pkg::DATA_W-1:0]    data_byte_i,
  input  logic [fbp_pkg::IDX_W-1:0]     frame_index_i,
  input  logic [fbp_pkg::SIZE_W-1:0]    frame_size_i,
  input  logic [fbp_pkg::PSIZE_W-1:0]   payload_size_i,
  input  logic                          full_i,
  output logic                          push_o,
  output fbp_pkg::fbp_entry_t           entry_o
);
  import fbp_pkg::*;

  logic [SIZE_W-1:0]  offset_q, offset_d;
  logic [PSIZE_W-1:0] fill_q, fill_d;
  logic [IDX_W-1:0]   pnum_q, pnum_d;
  logic [IDX_W-1:0]   hidx_q, hidx_d;
  logic [SIZE_W-1:0]  hsize_q, hsize_d;

  logic               first, drop, accept, fend, pend;
  logic [IDX_W-1:0]   eff_idx, eff_pnum;
  logic [SIZE_W-1:0]  eff_size;
  logic [PSIZE_W-1:0] eff_fill, limit;

  always_comb begin
    if (payload_size_i == '0) begin
      limit = PSIZE_W'(1);
    end else if (payload_size_i > PAYLOAD_MAX) begin
      limit = PAYLOAD_MAX;
    end else begin
      limit = payload_size_i;
    end
  end

  assign first    = (offset_q == '0);
  assign drop     = first && (frame_size_i == '0);
  assign eff_idx  = first ? frame_index_i : hidx_q;
  assign eff_size = first ? frame_size_i  : hsize_q;
  assign eff_fill = first ? '0 : fill_q;
  assign eff_pnum = first ? '0 : pnum_q;

  assign fend = ({1'b0, offset_q} + (SIZE_W+1)'(1)) >= {1'b0, eff_size};
  assign pend = fend || (({1'b0, eff_fill} + (PSIZE_W+1)'(1)) >= {1'b0, limit});

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign push_o     = accept && !drop;

  always_comb begin
    entry_o.data_byte     = data_byte_i;
    entry_o.need_hdr      = (eff_fill == '0);
    entry_o.frame_index   = eff_idx;
    entry_o.packet_number = eff_pnum;
    entry_o.frame_size    = eff_size;
    entry_o.packet_end    = pend;
    entry_o.frame_end     = fend;
  end

  always_comb begin
    offset_d = offset_q;
    fill_d   = fill_q;
    pnum_d   = pnum_q;
    hidx_d   = hidx_q;
    hsize_d  = hsize_q;
    if (push_o) begin
      hidx_d  = eff_idx;
      hsize_d = eff_size;
      if (fend) begin
        offset_d = '0;
        fill_d   = '0;
        pnum_d   = '0;
      end else begin
        offset_d = offset_q + SIZE_W'(1);
        if (pend) begin
          fill_d = '0;
          pnum_d = eff_pnum + IDX_W'(1);
        end else begin
          fill_d = eff_fill + PSIZE_W'(1);
          pnum_d = eff_pnum;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      fill_q   <= '0;
      pnum_q   <= '0;
      hidx_q   <= '0;
      hsize_q  <= '0;
    end else begin
      offset_q <= offset_d;
      fill_q   <= fill_d;
      pnum_q   <= pnum_d;
      hidx_q   <= hidx_d;
      hsize_q  <= hsize_d;
    end
  end

endmodule

// File: design/fbp_fifo.sv
`timescale 1ns / 1ps
module fbp_fifo #(
  parameter int DEPTH = fbp_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  fbp_pkg::fbp_entry_t entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output fbp_pkg::fbp_entry_t head_o
);
  import fbp_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  fbp_entry_t         slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = slot_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: design/fbp_back.sv
`timescale 1ns / 1ps
module fbp_back (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  fbp_pkg::fbp_entry_t               head_i,
  output logic                              pop_o,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [fbp_pkg::DATA_W-1:0]        m_axis_tdata,
  output logic [fbp_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
  output logic                              m_axis_tlast
);
  import fbp_pkg::*;

  logic [STEP_W-1:0]      step_q, step_d;
  logic                   tvalid_q, tvalid_d;
  logic [DATA_W-1:0]      tdata_q, tdata_d;
  logic [OUT_TUSER_W-1:0] tuser_q, tuser_d;
  logic                   tlast_q, tlast_d;
  logic                   load, in_hdr;

  // Header bytes come first while the step counter runs below the header length
  assign in_hdr = head_i.need_hdr && (step_q != STEP_W'(HDR_BYTES));
  assign load   = valid_i && (!tvalid_q || m_axis_tready);
  assign pop_o  = load && !in_hdr;

  always_comb begin
    step_d   = step_q;
    tvalid_d = tvalid_q;
    tdata_d  = tdata_q;
    tuser_d  = tuser_q;
    tlast_d  = tlast_q;
    if (load) begin
      step_d   = in_hdr ? step_q + STEP_W'(1) : '0;
      tvalid_d = 1'b1;
      tdata_d  = in_hdr ? fbp_hdr_byte(head_i, step_q[HSEL_W-1:0]) : head_i.data_byte;
      tuser_d  = {head_i.frame_end && !in_hdr, head_i.packet_end && !in_hdr, in_hdr};
      tlast_d  = !in_hdr;
    end else if (m_axis_tready) begin
      tvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q   <= '0;
      tvalid_q <= 1'b0;
    end else begin
      step_q   <= step_d;
      tvalid_q <= tvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tdata_q <= tdata_d;
    tuser_q <= tuser_d;
    tlast_q <= tlast_d;
  end

  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tdata  = tdata_q;
  assign m_axis_tuser  = tuser_q;
  assign m_axis_tlast  = tlast_q;

endmodule

// File: bench/frame_byte_packetizer_top_tb.sv
`timescale 1ns / 1ps
module frame_byte_packetizer_top_tb;
  import fbp_pkg::*;

  localparam int CYCLE_LIMIT = 100_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int IDLE_PCT = 34;

  // One frame byte as it travels on the input stream (first field highest)
  typedef struct packed {
    logic [SIZE_W-1:0] frame_size;
    logic [IDX_W-1:0]  frame_index;
    logic [DATA_W-1:0] data_byte;
  } frame_byte_t;

  // One byte of the packet stream
  typedef struct packed {
    logic [DATA_W-1:0] out_byte;
    logic              is_header;
    logic              packet_end;
    logic              frame_end;
    logic              last_of_run;
  } packet_byte_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [DATA_W-1:0]      m_axis_tdata;
  logic [OUT_TUSER_W-1:0] m_axis_tuser;
  logic                   m_axis_tlast;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [PSIZE_W-1:0]     cfg_data_i = '0;

  frame_byte_t  pending_bytes[$];
  packet_byte_t expected_stream[$];

  // Shadow of the block's register and frame/packet counters
  logic [PSIZE_W-1:0] payload_setting = PAYLOAD_RESET;
  logic [SIZE_W-1:0]  bytes_into_frame = '0;
  logic [PSIZE_W-1:0] bytes_into_packet = '0;
  logic [IDX_W-1:0]   packet_seq = '0;
  logic [IDX_W-1:0]   frame_id_held = '0;
  logic [SIZE_W-1:0]  frame_len_held = '0;

  int   cycle_count = 0;
  int   mismatch_count = 0;
  logic item_taken = 1'b0;
  logic no_idle = 1'b0;
  logic rx_hold = 1'b0;
  logic hold_off_request = 1'b0;

  frame_byte_packetizer_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Work out the packet bytes that one accepted frame byte brings out, and
  // advance the shadow counters the way the block does.
  task automatic packetize_byte(input frame_byte_t fb);
    logic [PSIZE_W-1:0] limit;
    logic               fend;
    logic               pend;
    logic [DATA_W-1:0]  hdr [HDR_BYTES];
    limit = payload_setting;
    if (limit == '0) limit = 14'd1;
    if (limit > PAYLOAD_MAX) limit = PAYLOAD_MAX;
    if (bytes_into_frame == '0) begin
      // drop a frame opener that claims zero length, state untouched
      if (fb.frame_size == '0) return;
      frame_id_held = fb.frame_index;
      frame_len_held = fb.frame_size;
      bytes_into_packet = '0;
      packet_seq = '0;
    end
    if (bytes_into_packet == '0) begin
      hdr[0] = frame_id_held[15:8];
      hdr[1] = frame_id_held[7:0];
      hdr[2] = packet_seq[15:8];
      hdr[3] = packet_seq[7:0];
      hdr[4] = {1'b0, frame_len_held[30:24]};
      hdr[5] = frame_len_held[23:16];
      hdr[6] = frame_len_held[15:8];
      hdr[7] = frame_len_held[7:0];
      for (int i = 0; i < HDR_BYTES; i++)
        expected_stream.push_back('{hdr[i], 1'b1, 1'b0, 1'b0, 1'b0});
    end
    fend = ({1'b0, bytes_into_frame} + 32'd1) >= {1'b0, frame_len_held};
    pend = fend || (({18'd0, bytes_into_packet} + 32'd1) >= {18'd0, limit});
    expected_stream.push_back('{fb.data_byte, 1'b0, pend, fend, 1'b1});
    if (fend) begin
      bytes_into_frame = '0;
      bytes_into_packet = '0;
      packet_seq = '0;
    end else begin
      bytes_into_frame = bytes_into_frame + 1'b1;
      if (pend) begin
        bytes_into_packet = '0;
        packet_seq = packet_seq + 1'b1;
      end else begin
        bytes_into_packet = bytes_into_packet + 1'b1;
      end
    end
  endtask

  // Sample both handshakes at the rising edge: feed accepted frame bytes to
  // the predictor and check each packet byte against the oldest expectation.
  always @(posedge clk_i) begin : monitor
    packet_byte_t seen;
    packet_byte_t want;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
    item_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      packetize_byte(frame_byte_t'(s_axis_tdata[SIZE_W+IDX_W+DATA_W-1:0]));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = '{m_axis_tdata, m_axis_tuser[0], m_axis_tuser[1], m_axis_tuser[2],
               m_axis_tlast};
      if (expected_stream.size() == 0) begin
        mismatch_count <= mismatch_count + 1;
        if (mismatch_count < 20)
          $display("%0t: unexpected packet byte %h hdr=%b pend=%b fend=%b last=%b",
                   $time, seen.out_byte, seen.is_header, seen.packet_end,
                   seen.frame_end, seen.last_of_run);
      end else begin
        want = expected_stream.pop_front();
        if (seen != want) begin
          mismatch_count <= mismatch_count + 1;
          if (mismatch_count < 20)
            $display({"%0t: mismatch, expected byte=%h hdr=%b pend=%b fend=%b ",
                      "last=%b, actual byte=%h hdr=%b pend=%b fend=%b last=%b"},
                     $time, want.out_byte, want.is_header, want.packet_end,
                     want.frame_end, want.last_of_run, seen.out_byte,
                     seen.is_header, seen.packet_end, seen.frame_end,
                     seen.last_of_run);
        end
      end
    end
  end

  // Sender: hold the current item until taken, then offer the next one or
  // idle at random; drive noise on tdata while idle.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || item_taken) begin
      if (pending_bytes.size() != 0 &&
          (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {1'b0, pending_bytes.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= IN_TDATA_W'({$urandom, $urandom});
      end
    end
  end

  // Receiver: stall at random unless told to hold off or to run flat out
  always @(negedge clk_i) begin
    if (!rst_ni || rx_hold)
      m_axis_tready <= 1'b0;
    else if (no_idle)
      m_axis_tready <= 1'b1;
    else
      m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
  end

  // Long hold-off on the output so the block fills and stalls its input
  initial begin
    wait (hold_off_request);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  task automatic push_byte(input logic [DATA_W-1:0] b, input logic [IDX_W-1:0] idx,
                           input logic [SIZE_W-1:0] len);
    pending_bytes.push_back('{len, idx, b});
  endtask

  // Queue one whole frame; bytes after the first may carry noise in the fields
  // the block only samples on the first byte.
  task automatic queue_frame(input logic [IDX_W-1:0] idx, input int len);
    for (int k = 0; k < len; k++) begin
      if (k == 0 || $urandom_range(1) == 0)
        push_byte(DATA_W'($urandom), idx, SIZE_W'(len));
      else
        push_byte(DATA_W'($urandom), IDX_W'($urandom), SIZE_W'($urandom));
    end
  endtask

  // Queue whole frames, mostly short, now and then a longer one or a
  // zero-length opener that should be dropped.
  task automatic queue_random_frames(input int target);
    int count;
    int len;
    count = 0;
    while (count < target) begin
      if ($urandom_range(9) == 0)
        push_byte(DATA_W'($urandom), IDX_W'($urandom), '0);
      len = ($urandom_range(7) == 0) ? $urandom_range(41, 120) : $urandom_range(1, 40);
      queue_frame(IDX_W'($urandom), len);
      count += len;
    end
  endtask

  // Return once nothing is queued, offered or expected, plus settling time
  task automatic wait_idle();
    while (pending_bytes.size() != 0 || s_axis_tvalid || expected_stream.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_payload_size(input logic [PSIZE_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    payload_setting = value;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
    cfg_data_i = PSIZE_W'($urandom);
  endtask

  initial begin : stimulus
    logic [PSIZE_W-1:0] sweep [8];
    sweep = '{14'd1, 14'd2, 14'd3, 14'd7, 14'd9000, 14'd16383,
              PSIZE_W'($urandom_range(4, 48)), 14'd8999};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset payload size: zero-length opener, one-byte frames at the field
    // extremes, and a short frame whose later bytes carry a zero and a maximal size.
    push_byte(8'hFF, 16'hFFFF, '0);
    push_byte(8'hFF, 16'hFFFF, 31'd1);
    push_byte(8'h00, 16'h0000, 31'd1);
    push_byte(8'h00, 16'hA5C3, 31'd3);
    push_byte(8'h80, 16'h0000, '0);
    push_byte(8'h7F, 16'hFFFF, 31'h7FFF_FFFF);
    wait_idle();

    // Two-byte packets across a five-byte frame
    write_payload_size(14'd2);
    push_byte(8'h11, 16'h1234, 31'd5);
    push_byte(8'h22, 16'h0000, '0);
    push_byte(8'h33, 16'hFFFF, 31'd1);
    push_byte(8'h44, 16'h1234, 31'd5);
    push_byte(8'h55, 16'h1234, 31'd5);
    wait_idle();

    // Lower the payload size while a packet is partly full: the next byte
    // must close the packet.
    write_payload_size(14'd8);
    for (int k = 0; k < 6; k++) push_byte(DATA_W'($urandom), 16'h5A5A, 31'd12);
    wait_idle();
    write_payload_size(14'd3);
    for (int k = 0; k < 6; k++) push_byte(DATA_W'($urandom), 16'h5A5A, 31'd12);
    wait_idle();

    // Oversized setting clamps to the hard maximum; the frame fits one packet
    write_payload_size(14'd16383);
    queue_frame(16'hC0DE, 30);
    wait_idle();

    // Zero setting acts as one byte per packet; run it with no idling on
    // either side.
    write_payload_size('0);
    no_idle = 1'b1;
    queue_frame(16'hBEEF, 40);
    wait_idle();
    no_idle = 1'b0;

    // Random frames across a sweep of settings
    foreach (sweep[i]) begin
      write_payload_size(sweep[i]);
      queue_random_frames(25);
      if (i == 0) hold_off_request = 1'b1;
      wait_idle();
    end

    // Leave a frame open whose size sets the top header bits
    write_payload_size(14'd3);
    for (int k = 0; k < 5; k++)
      push_byte(DATA_W'($urandom), IDX_W'($urandom),
                {1'b1, 30'($urandom)});
    wait_idle();

    if (mismatch_count == 0 && expected_stream.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
